@@ rtl/core/lzw_pkg.sv @@
// Package with the shared constants, state type and control structs of the LZW encoder.
`timescale 1ns / 1ps

package lzw_pkg;

  // Default code width and the first dictionary code.
  localparam int CODE_BITS_DEF = 12;
  localparam int FIRST_CODE    = 256;
  localparam int BYTE_BITS     = 8;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HREAD,
    ST_DREAD,
    ST_CHECK,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic hash_rd;
    logic dict_rd;
    logic probe_next;
    logic take_hit;
    logic take_miss;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic queue_empty;
    logic prefix_valid;
    logic eom;
    logic live;
    logic match;
  } status_t;

endpackage

@@ rtl/core/lzw_byte_if.sv @@
// Interface carrying input byte requests.
`timescale 1ns / 1ps

interface lzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ rtl/core/lzw_code_if.sv @@
// Interface carrying output code requests.
`timescale 1ns / 1ps

interface lzw_code_if #(
  parameter int CODE_BITS = lzw_pkg::CODE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code_word;
  logic                 last_code;

  modport source (output valid, output code_word, output last_code, input ready);
  modport sink   (input valid, input code_word, input last_code, output ready);
endinterface

@@ rtl/core/lzw_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/lzw_ctrl.sv @@
// Controller state machine of the LZW encoder.
`timescale 1ns / 1ps

module lzw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lzw_pkg::status_t status,
  output lzw_pkg::cmd_t    cmd
);
  import lzw_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && status.queue_empty) begin
          state_next = status.prefix_valid ? ST_HREAD : ST_FIN;
        end
      end
      ST_HREAD: state_next = ST_DREAD;
      ST_DREAD: state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.live && !status.match) state_next = ST_HREAD;
        else state_next = ST_FIN;
      end
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready   = status.queue_empty;
        cmd.accept = in_valid && status.queue_empty;
      end
      ST_HREAD: cmd.hash_rd = 1'b1;
      ST_DREAD: cmd.dict_rd = 1'b1;
      ST_CHECK: begin
        cmd.take_hit   = status.live && status.match;
        cmd.probe_next = status.live && !status.match;
        cmd.take_miss  = !status.live;
      end
      ST_FIN:   cmd.flush = status.eom;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/lzw_dp.sv @@
// Datapath of the LZW encoder: prefix, hashed dictionary and output queue.
`timescale 1ns / 1ps

module lzw_dp #(
  parameter int CODE_BITS = lzw_pkg::CODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lzw_pkg::cmd_t        cmd,
  output lzw_pkg::status_t     status,
  input  logic [7:0]           in_byte,
  input  logic                 in_eom,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] out_code,
  output logic                 out_last
);
  import lzw_pkg::*;

  localparam int CB       = CODE_BITS;
  localparam int DICT_D   = (1 << CB) - FIRST_CODE;
  localparam int DICT_AW  = $clog2(DICT_D);
  localparam int KEY_W    = CB + BYTE_BITS;
  localparam int DICT_W   = KEY_W + CB;

  logic [7:0]    byte_r;
  logic          eom_r;
  logic [CB-1:0] prefix;
  logic          prefix_valid;
  logic [CB:0]   nfc;
  logic [CB-1:0] slot;
  logic [CB:0]   clr_cnt;
  logic [CB-1:0] q_code [2];
  logic          q_last [2];
  logic [1:0]    cnt;

  logic          room;
  logic          clr_done;
  logic [CB-1:0] hash_w;
  logic [CB-1:0] code_c;
  logic [DICT_W-1:0] d_rdata;
  logic          h_we;
  logic [CB-1:0] h_waddr;
  logic [CB-1:0] h_wdata;
  logic          ins;
  logic          push;
  logic          pop;
  logic [CB-1:0] push_code;
  logic [1:0]    idx;
  logic [CB-1:0] first_c;

  assign first_c  = CB'(FIRST_CODE);
  assign room     = !nfc[CB];
  assign clr_done = clr_cnt[CB];
  assign hash_w   = prefix ^ (CB'(in_byte) << (CB - BYTE_BITS));
  assign ins      = cmd.take_miss && room;

  // Hash table: slot to code; cleared once after reset.
  assign h_we    = (cmd.clear_step && !clr_done) || ins;
  assign h_waddr = clr_done ? slot : clr_cnt[CB-1:0];
  assign h_wdata = clr_done ? nfc[CB-1:0] : '0;

  lzw_ram #(.WIDTH(CB), .DEPTH(1 << CB)) u_hash (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (cmd.hash_rd),
    .raddr (slot),
    .rdata (code_c)
  );

  // Dictionary: code to (key, home slot).
  lzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_D)) u_dict (
    .clk   (clk),
    .we    (ins),
    .waddr (DICT_AW'(nfc[CB-1:0] - first_c)),
    .wdata ({prefix, byte_r, slot}),
    .re    (cmd.dict_rd),
    .raddr (DICT_AW'(code_c - first_c)),
    .rdata (d_rdata)
  );

  // An entry is live only if its code is in use and it points back to this slot.
  always_comb begin
    status.clear_done   = clr_done;
    status.queue_empty  = (cnt == 2'd0);
    status.prefix_valid = prefix_valid;
    status.eom          = eom_r;
    status.live         = (code_c >= first_c) && ({1'b0, code_c} < nfc)
                          && (d_rdata[CB-1:0] == slot);
    status.match        = (d_rdata[DICT_W-1:CB] == {prefix, byte_r});
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step && !clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Prefix and free code.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_valid <= 1'b0;
      prefix       <= '0;
      nfc          <= (CB+1)'(FIRST_CODE);
    end else begin
      if (cmd.accept && !prefix_valid) begin
        prefix       <= CB'(in_byte);
        prefix_valid <= 1'b1;
      end
      if (cmd.take_hit) begin
        prefix <= code_c;
      end
      if (cmd.take_miss) begin
        prefix <= CB'(byte_r);
        if (room) nfc <= nfc + 1'b1;
      end
      if (cmd.flush) begin
        prefix_valid <= 1'b0;
        prefix       <= '0;
        nfc          <= (CB+1)'(FIRST_CODE);
      end
    end
  end

  // Request payload and probe position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      eom_r  <= in_eom;
      slot   <= hash_w;
    end else if (cmd.probe_next) begin
      slot <= slot + 1'b1;
    end
  end

  // Two-entry output queue.
  assign push      = cmd.take_miss || cmd.flush;
  assign push_code = prefix;
  assign pop       = out_valid && out_ready;
  assign idx       = cnt - {1'b0, pop};
  assign out_valid = (cnt != 2'd0);
  assign out_code  = q_code[0];
  assign out_last  = q_last[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // The head takes a new code when it lands there, else the second entry moves up.
  always_ff @(posedge clk) begin
    if (push && (idx == 2'd0)) begin
      q_code[0] <= push_code;
      q_last[0] <= cmd.flush;
    end else if (pop) begin
      q_code[0] <= q_code[1];
      q_last[0] <= q_last[1];
    end
    if (push && (idx == 2'd1)) begin
      q_code[1] <= push_code;
      q_last[1] <= cmd.flush;
    end
  end

endmodule

@@ rtl/core/lzw_byte_encoder.sv @@
// Top level of the LZW byte encoder: controller, datapath and checks.
//
//   Channel    Direction  Payload                       Handshake
//   byte_in    in         data_byte[7:0], end_of_message valid/ready
//   code_out   out        code_word[CODE_BITS-1:0], last_code valid/ready
//
// A byte with no prefix held goes from idle straight to the finishing step;
// otherwise each hash probe (hash RAM read, dictionary RAM read, compare)
// precedes the finishing step. After reset a sweep over all 2^CODE_BITS hash
// slots clears the hash table before the first request. A new byte is taken
// only once the output queue has drained, so a stalled output holds it back.
`timescale 1ns / 1ps

module lzw_byte_encoder #(
  parameter int CODE_BITS = lzw_pkg::CODE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lzw_byte_if.sink   byte_in,
  lzw_code_if.source code_out
);
  import lzw_pkg::*;

  cmd_t    cmd;
  status_t status;

  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lzw_dp #(.CODE_BITS(CODE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (byte_in.data_byte),
    .in_eom    (byte_in.end_of_message),
    .out_valid (code_out.valid),
    .out_ready (code_out.ready),
    .out_code  (code_out.code_word),
    .out_last  (code_out.last_code)
  );

  // A byte is taken only after clearing and with an empty output queue.
  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    (byte_in.valid && byte_in.ready) |-> (status.clear_done && status.queue_empty))
    else $error("byte taken while busy");

  // A hit needs a live, matching entry.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hit |-> (status.live && status.match))
    else $error("hit without live match");

  // At most one prefix action per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.probe_next, cmd.take_hit, cmd.take_miss, cmd.flush}))
    else $error("conflicting commands");

  // A miss is always followed by the finishing step.
  a_miss_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.take_miss |=> !cmd.accept && !cmd.hash_rd)
    else $error("miss not followed by finish");

endmodule

@@ test/lzw_byte_encoder_test.sv @@
// Self-checking testbench for the LZW byte encoder with random request gaps and output stalls.
`timescale 1ns / 1ps

module lzw_byte_encoder_test;

  localparam int CODE_BITS  = lzw_pkg::CODE_BITS_DEF;
  localparam int CODE_LIMIT = 1 << CODE_BITS;
  localparam int DICT_DEPTH = CODE_LIMIT - lzw_pkg::FIRST_CODE;
  localparam int IDLE_LIMIT = 40000;
  localparam int NUM_ITEMS  = 1150;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_req_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code_word;
    logic                 last_code;
  } code_res_t;

  logic clk;
  logic rst;

  lzw_byte_if              byte_in ();
  lzw_code_if #(CODE_BITS) code_out ();

  lzw_byte_encoder #(.CODE_BITS(CODE_BITS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in.sink),
    .code_out (code_out.source)
  );

  // Encoder state mirrored by the predictor.
  logic [CODE_BITS+7:0] dict_keys [DICT_DEPTH];
  int unsigned          next_code;
  logic [CODE_BITS-1:0] cur_prefix;
  bit                   have_prefix;

  byte_req_t pending_bytes[$];
  code_res_t expected_codes[$];
  int        errors;
  int        idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the codes that one accepted byte produces.
  task automatic encode_byte(input byte_req_t req);
    logic [CODE_BITS+7:0] key;
    int unsigned hit;
    begin
      if (!have_prefix) begin
        cur_prefix  = CODE_BITS'(req.data_byte);
        have_prefix = 1'b1;
      end else begin
        key = {cur_prefix, req.data_byte};
        hit = 0;
        for (int i = 0; i < int'(next_code) - lzw_pkg::FIRST_CODE; i++) begin
          if (hit == 0 && dict_keys[i] == key) hit = lzw_pkg::FIRST_CODE + i;
        end
        if (hit != 0) begin
          cur_prefix = CODE_BITS'(hit);
        end else begin
          expected_codes.insert(expected_codes.size(), '{cur_prefix, 1'b0});
          if (next_code < CODE_LIMIT) begin
            dict_keys[next_code - lzw_pkg::FIRST_CODE] = key;
            next_code++;
          end
          cur_prefix = CODE_BITS'(req.data_byte);
        end
      end
      if (req.end_of_message) begin
        expected_codes.insert(expected_codes.size(), '{cur_prefix, 1'b1});
        have_prefix = 1'b0;
        cur_prefix  = '0;
        next_code   = lzw_pkg::FIRST_CODE;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    begin
      $display("%0t: mismatch: %s", $realtime, what);
      errors++;
    end
  endtask

  // Appends one byte request to the pending list.
  task automatic queue_byte(input logic [7:0] b, input logic eom);
    byte_req_t req;
    begin
      req.data_byte      = b;
      req.end_of_message = eom;
      pending_bytes.insert(pending_bytes.size(), req);
    end
  endtask

  // Queues one message of the given length drawn from a small alphabet or the full byte range.
  task automatic queue_message(input int len, input int alphabet);
    begin
      for (int i = 0; i < len; i++) begin
        queue_byte((alphabet >= 256) ? 8'($urandom)
                   : 8'($urandom_range(alphabet - 1) + 8'h41),
                   (i == len - 1));
      end
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      byte_in.valid          <= 1'b0;
      byte_in.data_byte      <= '0;
      byte_in.end_of_message <= 1'b0;
      burst_left             <= 0;
      gap_left               <= 0;
    end else if (!byte_in.valid || byte_in.ready) begin
      if (byte_in.valid) encode_byte({byte_in.data_byte, byte_in.end_of_message});
      if (gap_left > 0) begin
        byte_in.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_bytes.size() > 0) begin
        byte_in.valid                                <= 1'b1;
        {byte_in.data_byte, byte_in.end_of_message} <= pending_bytes.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(30, 1);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        byte_in.valid <= 1'b0;
      end
    end
  end

  // Output stall pattern: alternating phases of free flow and stalls.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      code_out.ready <= 1'b0;
      stall_phase    <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) code_out.ready <= 1'b1;
      else code_out.ready <= ($urandom_range(3) != 0);
    end
  end

  // Result monitor and inactivity watchdog.
  always @(posedge clk) begin
    code_res_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((byte_in.valid && byte_in.ready) || (code_out.valid && code_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (code_out.valid && code_out.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code %0d", code_out.code_word));
        end else begin
          want = expected_codes.pop_front();
          if (code_out.code_word !== want.code_word)
            report_mismatch($sformatf("code_word %0d, expected %0d",
                                      code_out.code_word, want.code_word));
          if (code_out.last_code !== want.last_code)
            report_mismatch($sformatf("last_code %0b, expected %0b",
                                      code_out.last_code, want.last_code));
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("** lzw_byte_encoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    errors        = 0;
    next_code     = lzw_pkg::FIRST_CODE;
    cur_prefix    = '0;
    have_prefix   = 1'b0;
    rst           = 1'b1;

    // Directed: single-byte messages at the byte extremes.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // Repeated byte builds and reuses dictionary entries.
    for (int i = 0; i < 8; i++) queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b1);
    // Classic pattern with hits on multi-byte entries, ending on a hit.
    for (int i = 0; i < 7; i++) queue_byte((i % 2) ? 8'h42 : 8'h41, (i == 6));
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);

    // Long messages: one over the full byte range, one over two symbols.
    queue_message(400, 256);
    queue_message(250, 2);
    // Random messages: mostly short with small alphabets, some full-range.
    while (pending_bytes.size() < NUM_ITEMS) begin
      queue_message($urandom_range(40, 1), ($urandom_range(4) == 0) ? 256
                    : $urandom_range(6, 1));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (pending_bytes.size() == 0);
    @(posedge clk);
    while (byte_in.valid) @(posedge clk);
    while (expected_codes.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** lzw_byte_encoder: PASSED **");
    end else begin
      $display("** lzw_byte_encoder: FAILED **");
    end
    $finish;
  end

endmodule
